/* rtl/gic_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad input conditioner package
// Shared widths, register indexes, state types and the fixed-point helpers
// that turn raw stick and trigger counts into magnitudes.
// ----------------------------------------------------------------------------
package gic_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAG_W      = FRAC_BITS + 1;
  localparam int RAW_W      = 16;
  localparam int TRIG_W     = 15;
  localparam int OUT_W      = 18;
  localparam int TRIG_OUT_W = 17;
  localparam int BTN_W      = 14;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int RAW_FULL   = 32767;

  localparam logic [MAG_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_FLOOR = 1'b1;

  localparam logic [FRAC_BITS-1:0] DZ_RESET = 16'd10486;
  localparam logic [CFG_W-1:0]     TF_RESET = 17'd3932;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_SUM,
    ST_ROOT,
    ST_CHECK,
    ST_SCALE,
    ST_MUL,
    ST_QUO,
    ST_DONE
  } stk_state_t;

  typedef enum logic {
    TOP_IDLE,
    TOP_BUSY
  } top_state_t;

  typedef struct packed {
    logic start;
    logic take;
  } stk_ctl_t;

  // A positive count r scaled by ONE / 32767, which is 2r plus a small carry.
  function automatic logic [MAG_W-1:0] half_norm(input logic [TRIG_W-1:0] r);
    logic [MAG_W-1:0] d;
    d = MAG_W'({r, 1'b0});
    if (d == MAG_W'(2 * RAW_FULL)) begin
      half_norm = d + MAG_W'(2);
    end else if (d >= MAG_W'(RAW_FULL)) begin
      half_norm = d + MAG_W'(1);
    end else begin
      half_norm = d;
    end
  endfunction

  // Magnitude of a normalized stick axis; negative counts scale by ONE / 32768.
  function automatic logic [MAG_W-1:0] axis_mag(input logic [RAW_W-1:0] raw);
    logic [MAG_W-1:0] m;
    m = ONE - MAG_W'(raw);
    if (raw[RAW_W-1]) begin
      axis_mag = {m[MAG_W-2:0], 1'b0};
    end else begin
      axis_mag = half_norm(raw[TRIG_W-1:0]);
    end
  endfunction

  function automatic logic signed [OUT_W-1:0] signed_out(input logic [MAG_W-1:0] q,
                                                         input logic neg);
    logic signed [OUT_W-1:0] v;
    v = OUT_W'(q);
    signed_out = neg ? -v : v;
  endfunction

endpackage

/* rtl/gamepad_input_conditioner_top.sv */
// Each item runs through the bit-serial square, square root, scale divide,
// multiply and divide in each stick unit, one bit a cycle; no new item is
// taken until the result of the last one is loaded into the output register.
// A finished result waits in the output register while the next item is taken.
// Reset clears the previous buttons and loads the dead zone and trigger floor
// defaults; no clearing pass is needed.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad input conditioner
// Normalizes stick and trigger axes, applies a scaled radial dead zone per
// stick and a trigger floor, and finds newly pressed buttons.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner_top #(
  parameter int BUTTON_COUNT = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  pad_connected,
  input  logic signed [gic_pkg::RAW_W-1:0]      left_x_raw,
  input  logic signed [gic_pkg::RAW_W-1:0]      left_y_raw,
  input  logic signed [gic_pkg::RAW_W-1:0]      right_x_raw,
  input  logic signed [gic_pkg::RAW_W-1:0]      right_y_raw,
  input  logic [gic_pkg::TRIG_W-1:0]            left_trigger_raw,
  input  logic [gic_pkg::TRIG_W-1:0]            right_trigger_raw,
  input  logic [gic_pkg::BTN_W-1:0]             button_levels,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  connected,
  output logic signed [gic_pkg::OUT_W-1:0]      left_x,
  output logic signed [gic_pkg::OUT_W-1:0]      left_y,
  output logic signed [gic_pkg::OUT_W-1:0]      right_x,
  output logic signed [gic_pkg::OUT_W-1:0]      right_y,
  output logic [gic_pkg::TRIG_OUT_W-1:0]        left_trigger,
  output logic [gic_pkg::TRIG_OUT_W-1:0]        right_trigger,
  output logic [gic_pkg::BTN_W-1:0]             pressed_edges,
  output logic [1:0]                            held_shoulders,
  output logic                                  steering,
  input  logic                                  cfg_we,
  input  logic [gic_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gic_pkg::CFG_W-1:0]             cfg_data
);
  import gic_pkg::*;

  localparam int MASK_BITS = (BUTTON_COUNT < BTN_W) ? BUTTON_COUNT : BTN_W;
  localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((64'd1 << MASK_BITS) - 64'd1);

  top_state_t state, state_next;
  stk_ctl_t   ctl;
  logic       accept, load;

  logic [FRAC_BITS-1:0]  dead_zone;
  logic [CFG_W-1:0]      trigger_floor;
  logic [BTN_W-1:0]      prev_buttons;
  logic [BTN_W-1:0]      now_btn;
  logic [MAG_W-1:0]      lt_norm, rt_norm;

  logic                  conn_r;
  logic                  neg_lx, neg_ly, neg_rx, neg_ry;
  logic [MAG_W-1:0]      lt_r, rt_r;
  logic [BTN_W-1:0]      edges_r;
  logic [1:0]            shoulders_r;

  logic                  l_done, r_done;
  logic [MAG_W-1:0]      l_qx, l_qy, r_qx, r_qy;

  assign accept  = in_valid && in_ready;
  assign load    = l_done && (!out_valid || out_ready);
  assign now_btn = button_levels & BTN_MASK;
  assign lt_norm = half_norm(left_trigger_raw);
  assign rt_norm = half_norm(right_trigger_raw);

  gic_stick u_left (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .dz    (dead_zone),
    .ax_in (axis_mag(left_x_raw)),
    .ay_in (axis_mag(left_y_raw)),
    .done  (l_done),
    .qx    (l_qx),
    .qy    (l_qy)
  );

  gic_stick u_right (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .dz    (dead_zone),
    .ax_in (axis_mag(right_x_raw)),
    .ay_in (axis_mag(right_y_raw)),
    .done  (r_done),
    .qx    (r_qx),
    .qy    (r_qy)
  );

  always_comb begin
    state_next = state;
    case (state)
      TOP_IDLE: if (in_valid) state_next = TOP_BUSY;
      TOP_BUSY: if (load) state_next = TOP_IDLE;
      default:  state_next = TOP_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == TOP_IDLE);
    ctl.start = in_valid && (state == TOP_IDLE);
    ctl.take  = load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= TOP_IDLE;
      out_valid     <= 1'b0;
      prev_buttons  <= '0;
      dead_zone     <= DZ_RESET;
      trigger_floor <= TF_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEAD_ZONE:     dead_zone     <= cfg_data[FRAC_BITS-1:0];
          CFG_TRIGGER_FLOOR: trigger_floor <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        prev_buttons <= pad_connected ? now_btn : '0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The Y axes are negated, so a Y result is negative when its raw count is not.
  always_ff @(posedge clk) begin
    if (accept) begin
      conn_r      <= pad_connected;
      neg_lx      <= left_x_raw[RAW_W-1];
      neg_ly      <= ~left_y_raw[RAW_W-1];
      neg_rx      <= right_x_raw[RAW_W-1];
      neg_ry      <= ~right_y_raw[RAW_W-1];
      lt_r        <= ({1'b0, lt_norm} < {1'b0, trigger_floor}) ? '0 : lt_norm;
      rt_r        <= ({1'b0, rt_norm} < {1'b0, trigger_floor}) ? '0 : rt_norm;
      edges_r     <= now_btn & ~prev_buttons;
      shoulders_r <= now_btn[BTN_W-1:BTN_W-2];
    end
    if (load) begin
      connected      <= conn_r;
      left_x         <= conn_r ? signed_out(l_qx, neg_lx) : '0;
      left_y         <= conn_r ? signed_out(l_qy, neg_ly) : '0;
      right_x        <= conn_r ? signed_out(r_qx, neg_rx) : '0;
      right_y        <= conn_r ? signed_out(r_qy, neg_ry) : '0;
      left_trigger   <= conn_r ? lt_r : '0;
      right_trigger  <= conn_r ? rt_r : '0;
      pressed_edges  <= conn_r ? edges_r : '0;
      held_shoulders <= conn_r ? shoulders_r : '0;
      steering       <= conn_r && ((|l_qx) || (|l_qy) || (|r_qx) || (|r_qy) ||
                                   (|lt_r) || (|rt_r));
    end
  end

  a_sticks_in_step: assert property (@(posedge clk) disable iff (rst)
    l_done == r_done)
    else $error("Stick units finished in different cycles.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("Input ready right after an accepted item.");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("Loaded result not offered.");

  a_drain_clears_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !load) |=> !out_valid)
    else $error("Taken result offered twice.");

endmodule

/* rtl/gic_stick.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick radial dead zone unit
// Bit-serial square, square root, scale divide, multiply and divide that
// rescale one stick vector; the result is held in the done state until taken.
// ----------------------------------------------------------------------------
module gic_stick (
  input  logic                          clk,
  input  logic                          rst,
  input  gic_pkg::stk_ctl_t             ctl,
  input  logic [gic_pkg::FRAC_BITS-1:0] dz,
  input  logic [gic_pkg::MAG_W-1:0]     ax_in,
  input  logic [gic_pkg::MAG_W-1:0]     ay_in,
  output logic                          done,
  output logic [gic_pkg::MAG_W-1:0]     qx,
  output logic [gic_pkg::MAG_W-1:0]     qy
);
  import gic_pkg::*;

  localparam int W  = MAG_W;
  localparam int CW = $clog2(W);

  stk_state_t state, state_next;
  logic [CW-1:0]  cnt;
  logic [W-1:0]   ax, ay;
  logic [W:0]     hi_x, hi_y;
  logic [W-1:0]   lo_x, lo_y;
  logic [2*W-1:0] rad;
  logic [W:0]     rem;
  logic [W-1:0]   root;
  logic [W-1:0]   sc;
  logic           kill;
  logic           sat;

  logic [W-1:0]   mc_x, mc_y, div;
  logic [W:0]     sum_x, sum_y, r2x, r2y, r2s;
  logic [W+2:0]   r4, trial, r4_diff;
  logic           gex, gey, ges, ger;

  always_comb begin
    mc_x    = (state == ST_MUL) ? sc : ax;
    mc_y    = (state == ST_MUL) ? sc : ay;
    sum_x   = hi_x + (lo_x[0] ? {1'b0, mc_x} : '0);
    sum_y   = hi_y + (lo_y[0] ? {1'b0, mc_y} : '0);
    r4      = {rem, rad[2*W-1 -: 2]};
    trial   = {1'b0, root, 2'b01};
    ger     = (r4 >= trial);
    r4_diff = r4 - trial;
    div     = ONE - {1'b0, dz};
    r2s     = {rem[W-1:0], 1'b0};
    ges     = (r2s >= {1'b0, div});
    r2x     = {hi_x[W-1:0], lo_x[W-1]};
    r2y     = {hi_y[W-1:0], lo_y[W-1]};
    gex     = (r2x >= {1'b0, root});
    gey     = (r2y >= {1'b0, root});
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (ctl.start) state_next = ST_SQR;
      ST_SQR:   if (cnt == '0) state_next = ST_SUM;
      ST_SUM:   state_next = ST_ROOT;
      ST_ROOT:  if (cnt == '0) state_next = ST_CHECK;
      ST_CHECK: state_next = ST_SCALE;
      ST_SCALE: if (cnt == '0) state_next = ST_MUL;
      ST_MUL:   if (cnt == '0) state_next = ST_QUO;
      ST_QUO:   if (cnt == '0) state_next = ST_DONE;
      ST_DONE:  if (ctl.take) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    done = (state == ST_DONE);
    qx   = kill ? '0 : lo_x;
    qy   = kill ? '0 : lo_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (ctl.start) begin
          ax   <= ax_in;
          ay   <= ay_in;
          hi_x <= '0;
          lo_x <= ax_in;
          hi_y <= '0;
          lo_y <= ay_in;
          cnt  <= CW'(W - 1);
        end
      end
      ST_SQR, ST_MUL: begin
        hi_x <= {1'b0, sum_x[W:1]};
        lo_x <= {sum_x[0], lo_x[W-1:1]};
        hi_y <= {1'b0, sum_y[W:1]};
        lo_y <= {sum_y[0], lo_y[W-1:1]};
        cnt  <= (cnt == '0) ? CW'(W - 1) : cnt - 1'b1;
      end
      ST_SUM: begin
        rad  <= {hi_x[W-1:0], lo_x} + {hi_y[W-1:0], lo_y};
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(W - 1);
      end
      ST_ROOT: begin
        if (ger) begin
          rem  <= r4_diff[W:0];
          root <= {root[W-2:0], 1'b1};
        end else begin
          rem  <= r4[W:0];
          root <= {root[W-2:0], 1'b0};
        end
        rad <= {rad[2*W-3:0], 2'b00};
        cnt <= cnt - 1'b1;
      end
      ST_CHECK: begin
        kill <= (root == '0) || (root < {1'b0, dz});
        sat  <= root[W-1];
        rem  <= {1'b0, root - {1'b0, dz}};
        sc   <= '0;
        cnt  <= CW'(FRAC_BITS - 1);
      end
      ST_SCALE: begin
        rem <= ges ? r2s - {1'b0, div} : r2s;
        if (cnt == '0) begin
          sc   <= sat ? ONE : {sc[W-2:0], ges};
          hi_x <= '0;
          lo_x <= ax;
          hi_y <= '0;
          lo_y <= ay;
          cnt  <= CW'(W - 1);
        end else begin
          sc  <= {sc[W-2:0], ges};
          cnt <= cnt - 1'b1;
        end
      end
      ST_QUO: begin
        hi_x <= gex ? r2x - {1'b0, root} : r2x;
        lo_x <= {lo_x[W-2:0], gex};
        hi_y <= gey ? r2y - {1'b0, root} : r2y;
        lo_y <= {lo_y[W-2:0], gey};
        cnt  <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> state == ST_IDLE)
    else $error("Stick unit started while busy.");

  a_scale_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE && !kill && !sat) |-> rem < {1'b0, div})
    else $error("Scale divide remainder is not below the divisor.");

  a_quo_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QUO && !kill) |-> (hi_x < {1'b0, root} && hi_y < {1'b0, root}))
    else $error("Axis divide remainder is not below the magnitude.");

endmodule
